/* hw/rtl/amdfw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package amdfw_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 5;
  localparam int LABEL_W      = 8;

  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(16);

  localparam logic [1:0] OP_ADD_EDGE  = 2'd0;
  localparam logic [1:0] OP_DEL_EDGE  = 2'd1;
  localparam logic [1:0] OP_SET_LABEL = 2'd2;
  localparam logic [1:0] OP_WALK      = 2'd3;

  typedef struct packed {
    logic [1:0]         op;
    logic [VIDX_W-1:0]  from_vertex;
    logic [VIDX_W-1:0]  to_vertex;
    logic [LABEL_W-1:0] label_value;
  } in_item_t;

  typedef struct packed {
    logic [VIDX_W-1:0]  visited_vertex;
    logic [LABEL_W-1:0] visited_label;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic upd;
    logic start;
    logic push;
    logic pop;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic walk_ok;
    logic cand_empty;
    logic depth_one;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/amdfw_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module amdfw_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  input  logic [amdfw_pkg::CNT_W-1:0] cfg_data_i,
  input  amdfw_pkg::in_item_t         in_data_i,
  input  amdfw_pkg::dp_cmd_t          cmd_i,
  output amdfw_pkg::dp_sts_t          sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output amdfw_pkg::out_item_t        out_data_o
);
  import amdfw_pkg::*;

  logic [CNT_W-1:0]        count_q;
  logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
  logic [LABEL_W-1:0]      label_q [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited_q;
  logic [VIDX_W-1:0]       stack_q [MAX_VERTICES];
  logic [CNT_W-1:0]        depth_q;
  logic [VIDX_W-1:0]       pend_vtx_q;
  logic [LABEL_W-1:0]      pend_lbl_q;
  logic                    out_valid_q;
  out_item_t               out_data_q;

  logic [CNT_W-1:0]        n_eff;
  logic [MAX_VERTICES-1:0] vmask;
  logic                    from_ok;
  logic                    to_ok;
  logic [VIDX_W-1:0]       top_idx;
  logic [VIDX_W-1:0]       top_vtx;
  logic [MAX_VERTICES-1:0] cand;
  logic [VIDX_W-1:0]       next_vtx;
  logic [VIDX_W-1:0]       lbl_addr;
  logic [LABEL_W-1:0]      lbl_rd;
  logic                    out_free;

  always_comb begin
    n_eff = (count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_q;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      vmask[i] = (CNT_W'(i) < n_eff);
    end
  end

  assign from_ok  = ({1'b0, in_data_i.from_vertex} < n_eff);
  assign to_ok    = ({1'b0, in_data_i.to_vertex} < n_eff);
  assign top_idx  = VIDX_W'(depth_q - CNT_W'(1));
  assign top_vtx  = stack_q[top_idx];
  assign cand     = adj_q[top_vtx] & vmask & ~visited_q;

  // lowest set bit wins
  always_comb begin
    next_vtx = '0;
    for (int i = MAX_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        next_vtx = VIDX_W'(i);
      end
    end
  end

  assign lbl_addr = cmd_i.start ? in_data_i.from_vertex : next_vtx;
  assign lbl_rd   = label_q[lbl_addr];
  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.walk_ok    = (in_data_i.op == OP_WALK) && from_ok;
  assign sts_o.cand_empty = (cand == '0);
  assign sts_o.depth_one  = (depth_q == CNT_W'(1));
  assign sts_o.out_free   = out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      count_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        adj_q[i]   <= '0;
        label_q[i] <= '0;
      end
    end else if (cmd_i.upd && from_ok) begin
      case (in_data_i.op)
        OP_ADD_EDGE: begin
          if (to_ok) adj_q[in_data_i.from_vertex][in_data_i.to_vertex] <= 1'b1;
        end
        OP_DEL_EDGE: begin
          if (to_ok) adj_q[in_data_i.from_vertex][in_data_i.to_vertex] <= 1'b0;
        end
        OP_SET_LABEL: begin
          label_q[in_data_i.from_vertex] <= in_data_i.label_value;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      depth_q   <= '0;
    end else if (cmd_i.start) begin
      visited_q <= MAX_VERTICES'(1) << in_data_i.from_vertex;
      depth_q   <= CNT_W'(1);
    end else if (cmd_i.push) begin
      visited_q <= visited_q | (MAX_VERTICES'(1) << next_vtx);
      depth_q   <= depth_q + CNT_W'(1);
    end else if (cmd_i.pop || cmd_i.finish) begin
      depth_q   <= depth_q - CNT_W'(1);
    end
  end

  // path stack and the held result carry no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      stack_q[0] <= in_data_i.from_vertex;
      pend_vtx_q <= in_data_i.from_vertex;
      pend_lbl_q <= lbl_rd;
    end else if (cmd_i.push) begin
      stack_q[VIDX_W'(depth_q)] <= next_vtx;
      pend_vtx_q <= next_vtx;
      pend_lbl_q <= lbl_rd;
    end
  end

  // the held vertex goes out once the walk knows whether it is the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push || cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push || cmd_i.finish) begin
      out_data_q.visited_vertex <= pend_vtx_q;
      out_data_q.visited_label  <= pend_lbl_q;
      out_data_q.last           <= cmd_i.finish;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CNT_W'(MAX_VERTICES))
    else $error("walk stack depth out of range");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.push || cmd_i.finish) |-> out_free)
    else $error("result emitted into a busy output register");

  a_push_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> $countones(visited_q) == $past($countones(visited_q)) + 1)
    else $error("push did not mark exactly one new vertex");

  a_finish_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q && out_data_q.last && depth_q == '0)
    else $error("walk end did not produce a last result");
`endif

endmodule

`default_nettype wire

/* hw/rtl/amdfw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module amdfw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  amdfw_pkg::dp_sts_t sts_i,
  output amdfw_pkg::dp_cmd_t cmd_o
);
  import amdfw_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_q;
  logic state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.walk_ok) begin
            cmd_o.start = 1'b1;
            state_d     = ST_WALK;
          end else begin
            cmd_o.upd = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (sts_i.cand_empty) begin
          if (!sts_i.depth_one) begin
            cmd_o.pop = 1'b1;
          end else if (sts_i.out_free) begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end else if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/adjacency_matrix_depth_first_walk.sv */
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                 payload
// in        input      in_valid_i / in_ready_o   in_data_i  (op, vertices, label)
// out       output     out_valid_o / out_ready_i out_data_o (vertex, label, last)
// cfg       input      cfg_valid_i / cfg_ready_o cfg_data_i (vertex_count)
//
// Edge and label transactions are applied as they are accepted. A walk starts
// from its vertex and then makes one push or pop of the path stack per cycle unless
// an output stall holds it, set by the single neighbor scan (priority encoder) per cycle.
// The last result is registered in the cycle after the final pop; output stalls
// hold a push or the end of the walk, pops go on.
// Reset clears matrix and labels and sets the count to 16; no clearing pass is needed.

module adjacency_matrix_depth_first_walk (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  amdfw_pkg::in_item_t         in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output amdfw_pkg::out_item_t        out_data_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [amdfw_pkg::CNT_W-1:0] cfg_data_i
);
  import amdfw_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  amdfw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  amdfw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
